FILE: rtl/pkenv_pkg.sv
// shared constants, register codes and stage types for the peak envelope block
package pkenv_pkg;

  // default sizing
  localparam int MAX_CHANNELS_DEF = 8;
  localparam int MAX_BLOCK_DEF    = 4096;

  // field widths
  localparam int CH_W     = 3;
  localparam int SAMPLE_W = 16;
  localparam int MAG_W    = 15;
  localparam int COEF_W   = 16;
  localparam int BLEN_W   = 13;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_LENGTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA_ATTACK  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA_RELEASE = 2'd2;

  localparam logic [BLEN_W-1:0] RST_BLOCK_LENGTH = 13'd1024;

  // result queue
  localparam int OQ_DEPTH = 8;
  localparam int OQ_AW    = $clog2(OQ_DEPTH);
  localparam int PEND_W   = $clog2(OQ_DEPTH + 1);

  typedef struct packed {
    logic                       v;
    logic [CH_W-1:0]            ch;
    logic signed [SAMPLE_W-1:0] sample;
  } item_t;

  typedef struct packed {
    logic                       v;
    logic [CH_W-1:0]            ch;
    logic signed [SAMPLE_W-1:0] sample;
    logic [MAG_W-1:0]           env;
  } env_item_t;

  typedef struct packed {
    logic [CH_W-1:0]  ch;
    logic [MAG_W-1:0] max_raw;
    logic [MAG_W-1:0] max_env;
  } res_t;

  typedef struct packed {
    logic push;
    logic drop;
    res_t res;
  } blk_out_t;

endpackage

FILE: rtl/pkenv_if.sv
// valid/ready channels for samples and block results

interface pkenv_item_if;
  logic                                    valid;
  logic                                    ready;
  logic [pkenv_pkg::CH_W-1:0]              channel;
  logic signed [pkenv_pkg::SAMPLE_W-1:0]   sample;

  modport source (output valid, output channel, output sample, input ready);
  modport sink   (input valid, input channel, input sample, output ready);
endinterface

interface pkenv_res_if;
  logic                         valid;
  logic                         ready;
  logic [pkenv_pkg::CH_W-1:0]   out_channel;
  logic [pkenv_pkg::MAG_W-1:0]  max_raw;
  logic [pkenv_pkg::MAG_W-1:0]  max_env;

  modport source (output valid, output out_channel, output max_raw, output max_env,
                  input ready);
  modport sink   (input valid, input out_channel, input max_raw, input max_env,
                  output ready);
endinterface

FILE: rtl/pkenv_ram.sv
// generic single write, single read ram with registered read data
module pkenv_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read returns old contents on a same-address write
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/pkenv_env.sv
// envelope stage: per-channel envelope memory, attack/release update
module pkenv_env #(
  parameter int MAX_CHANNELS = pkenv_pkg::MAX_CHANNELS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  pkenv_pkg::item_t                 item,
  input  logic [pkenv_pkg::COEF_W-1:0]     alpha_attack,
  input  logic [pkenv_pkg::COEF_W-1:0]     alpha_release,
  output pkenv_pkg::env_item_t             env_o
);

  localparam int CH_AW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

  logic                                   s1_v;
  logic [pkenv_pkg::CH_W-1:0]             s1_ch;
  logic signed [pkenv_pkg::SAMPLE_W-1:0]  s1_sample;

  logic [CH_AW-1:0]                       raddr;
  logic [CH_AW-1:0]                       waddr;
  logic [pkenv_pkg::MAG_W-1:0]            ram_q;
  logic [MAX_CHANNELS-1:0]                vld;
  logic                                   vq;

  logic                                   byp_v;
  logic [pkenv_pkg::CH_W-1:0]             byp_ch;
  logic [pkenv_pkg::MAG_W-1:0]            byp_env;

  logic [pkenv_pkg::MAG_W-1:0]            env_cur;
  logic [pkenv_pkg::MAG_W-1:0]            mag;
  logic                                   decay;
  logic [pkenv_pkg::COEF_W:0]             op_a;
  logic [pkenv_pkg::MAG_W-1:0]            op_b;
  logic [31:0]                            prod;
  logic [15:0]                            prod_hi;
  logic [15:0]                            env_sum;
  logic [pkenv_pkg::MAG_W-1:0]            env_new;

  assign raddr = CH_AW'(item.ch);
  assign waddr = CH_AW'(s1_ch);

  pkenv_ram #(.WIDTH(pkenv_pkg::MAG_W), .DEPTH(MAX_CHANNELS)) u_ram (
    .clk   (clk),
    .we    (s1_v),
    .waddr (waddr),
    .wdata (env_new),
    .raddr (raddr),
    .rdata (ram_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v  <= 1'b0;
      byp_v <= 1'b0;
      vld   <= '0;
    end else begin
      s1_v  <= item.v;
      byp_v <= s1_v;
      if (s1_v) begin
        vld[waddr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    s1_ch     <= item.ch;
    s1_sample <= item.sample;
    vq        <= vld[raddr];
    byp_ch    <= s1_ch;
    byp_env   <= env_new;
  end

  // last write has not reached the ram read yet
  always_comb begin
    if (byp_v && (byp_ch == s1_ch)) begin
      env_cur = byp_env;
    end else if (vq) begin
      env_cur = ram_q;
    end else begin
      env_cur = '0;
    end
  end

  // magnitude, full-scale negative saturates
  always_comb begin
    if (s1_sample[15]) begin
      if (s1_sample == 16'sh8000) begin
        mag = 15'h7fff;
      end else begin
        mag = 15'(~s1_sample + 16'sd1);
      end
    end else begin
      mag = s1_sample[14:0];
    end
  end

  // one shared multiplier for decay and attack
  always_comb begin
    decay = env_cur > mag;
    if (decay) begin
      op_a = 17'h10000 - {1'b0, alpha_release};
      op_b = env_cur;
    end else begin
      op_a = {1'b0, alpha_attack};
      op_b = mag - env_cur;
    end
    prod    = {15'd0, op_a} * {17'd0, op_b};
    prod_hi = prod[31:16];
    env_sum = decay ? prod_hi : ({1'b0, env_cur} + prod_hi);
    env_new = (env_sum > 16'h7fff) ? 15'h7fff : env_sum[14:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      env_o.v <= 1'b0;
    end else begin
      env_o.v <= s1_v;
    end
    env_o.ch     <= s1_ch;
    env_o.sample <= s1_sample;
    env_o.env    <= env_new;
  end

endmodule

FILE: rtl/pkenv_blk.sv
// block stage: per-channel maxima and sample count memory, completion check
module pkenv_blk #(
  parameter int MAX_CHANNELS = pkenv_pkg::MAX_CHANNELS_DEF,
  parameter int MAX_BLOCK    = pkenv_pkg::MAX_BLOCK_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  pkenv_pkg::env_item_t             env_i,
  input  logic [pkenv_pkg::BLEN_W-1:0]     block_length,
  output pkenv_pkg::blk_out_t              blk_o
);

  localparam int CH_AW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int POS_W = $clog2(MAX_BLOCK);
  localparam int CMP_W = (POS_W + 1 > pkenv_pkg::BLEN_W) ? POS_W + 1 : pkenv_pkg::BLEN_W;
  localparam int MW    = pkenv_pkg::MAG_W;
  localparam int DW    = POS_W + 2 * MW;

  logic                                   st_v;
  logic [pkenv_pkg::CH_W-1:0]             st_ch;
  logic signed [pkenv_pkg::SAMPLE_W-1:0]  st_sample;
  logic [MW-1:0]                          st_env;

  logic [CH_AW-1:0]                       raddr;
  logic [CH_AW-1:0]                       waddr;
  logic [DW-1:0]                          ram_q;
  logic [MAX_CHANNELS-1:0]                vld;
  logic                                   vq;

  logic                                   byp_v;
  logic [pkenv_pkg::CH_W-1:0]             byp_ch;
  logic [DW-1:0]                          byp_d;

  logic [DW-1:0]                          cur;
  logic [POS_W-1:0]                       cur_pos;
  logic [MW-1:0]                          cur_envp;
  logic [MW-1:0]                          cur_raw;
  logic [MW-1:0]                          raw_new;
  logic [MW-1:0]                          envp_new;
  logic [POS_W:0]                         count;
  logic [CMP_W-1:0]                       blen;
  logic [CMP_W-1:0]                       eff_len;
  logic                                   emit;
  logic [DW-1:0]                          wdata;

  assign raddr = CH_AW'(env_i.ch);
  assign waddr = CH_AW'(st_ch);

  pkenv_ram #(.WIDTH(DW), .DEPTH(MAX_CHANNELS)) u_ram (
    .clk   (clk),
    .we    (st_v),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (ram_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st_v  <= 1'b0;
      byp_v <= 1'b0;
      vld   <= '0;
    end else begin
      st_v  <= env_i.v;
      byp_v <= st_v;
      if (st_v) begin
        vld[waddr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    st_ch     <= env_i.ch;
    st_sample <= env_i.sample;
    st_env    <= env_i.env;
    vq        <= vld[raddr];
    byp_ch    <= st_ch;
    byp_d     <= wdata;
  end

  always_comb begin
    if (byp_v && (byp_ch == st_ch)) begin
      cur = byp_d;
    end else if (vq) begin
      cur = ram_q;
    end else begin
      cur = '0;
    end
    cur_pos  = cur[DW-1 -: POS_W];
    cur_envp = cur[2*MW-1 -: MW];
    cur_raw  = cur[MW-1:0];
  end

  // zero length acts as one, long lengths clamp to the block limit
  always_comb begin
    blen = CMP_W'(block_length);
    if (blen == '0) begin
      eff_len = CMP_W'(1);
    end else if (blen > CMP_W'(MAX_BLOCK)) begin
      eff_len = CMP_W'(MAX_BLOCK);
    end else begin
      eff_len = blen;
    end
  end

  always_comb begin
    raw_new  = (!st_sample[15] && (st_sample[14:0] > cur_raw)) ? st_sample[14:0] : cur_raw;
    envp_new = (st_env > cur_envp) ? st_env : cur_envp;
    count    = {1'b0, cur_pos} + (POS_W + 1)'(1);
    emit     = CMP_W'(count) >= eff_len;
    wdata    = emit ? '0 : {count[POS_W-1:0], envp_new, raw_new};
  end

  assign blk_o.push        = st_v && emit;
  assign blk_o.drop        = st_v && !emit;
  assign blk_o.res.ch      = st_ch;
  assign blk_o.res.max_raw = raw_new;
  assign blk_o.res.max_env = envp_new;

endmodule

FILE: rtl/pkenv_oq.sv
// result queue between the block stage and the result channel
module pkenv_oq (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  pkenv_pkg::res_t  push_data,
  input  logic             pop,
  output logic             valid,
  output pkenv_pkg::res_t  data
);

  localparam int AW = pkenv_pkg::OQ_AW;

  pkenv_pkg::res_t   q [pkenv_pkg::OQ_DEPTH];
  logic [AW-1:0]     wr_ptr;
  logic [AW-1:0]     rd_ptr;
  logic [AW:0]       count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + AW'(1);
      end
      count <= count + (AW + 1)'(push) - (AW + 1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= push_data;
    end
  end

  assign valid = count != '0;
  assign data  = q[rd_ptr];

endmodule

FILE: rtl/peak_envelope_block_max_top.sv
// peak envelope follower with per-channel block maxima, top level
// result path: a block's last sample passes the envelope stage, envelope output and block
// stage registers, then the result queue count register, before peaks.valid rises
// throughput: one sample per cycle, any channel order, back-to-back repeats of one channel
// included, through forwarding in the envelope and block memories; samples.ready drops
// only when eight accepted samples are still owed a slot in the result queue
// reset (synchronous, rst high) loads block_length 1024 and zero coefficients, empties the
// pipeline and clears per-entry valid bits so every channel starts from zero
module peak_envelope_block_max_top #(
  parameter int MAX_CHANNELS = pkenv_pkg::MAX_CHANNELS_DEF,
  parameter int MAX_BLOCK    = pkenv_pkg::MAX_BLOCK_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                wr_en,
  input  logic [pkenv_pkg::CFG_IDX_W-1:0]     wr_index,
  input  logic [pkenv_pkg::CFG_DATA_W-1:0]    wr_data,
  pkenv_item_if.sink                          samples,
  pkenv_res_if.source                         peaks
);

  localparam int PW = pkenv_pkg::PEND_W;

  // configuration registers
  logic [pkenv_pkg::BLEN_W-1:0]  block_length;
  logic [pkenv_pkg::COEF_W-1:0]  alpha_attack;
  logic [pkenv_pkg::COEF_W-1:0]  alpha_release;

  // pipeline links
  pkenv_pkg::item_t       item;
  pkenv_pkg::env_item_t   env_item;
  pkenv_pkg::blk_out_t    blk_out;
  pkenv_pkg::res_t        oq_data;
  logic                   oq_valid;

  // credit tracking: samples accepted but not yet retired
  logic [PW-1:0]          pending;
  logic [PW-1:0]          pending_next;
  logic                   in_xfer;
  logic                   out_xfer;
  logic                   in_range;

  always_ff @(posedge clk) begin
    if (rst) begin
      block_length  <= pkenv_pkg::RST_BLOCK_LENGTH;
      alpha_attack  <= '0;
      alpha_release <= '0;
    end else if (wr_en) begin
      case (wr_index)
        pkenv_pkg::REG_BLOCK_LENGTH:  block_length  <= wr_data[pkenv_pkg::BLEN_W-1:0];
        pkenv_pkg::REG_ALPHA_ATTACK:  alpha_attack  <= wr_data;
        pkenv_pkg::REG_ALPHA_RELEASE: alpha_release <= wr_data;
        default: ;  // unused index, write dropped
      endcase
    end
  end

  assign in_xfer  = samples.valid && samples.ready;
  assign out_xfer = peaks.valid && peaks.ready;

  // samples on channels past the configured count are taken and ignored
  assign in_range = int'(samples.channel) < MAX_CHANNELS;

  assign item.v      = in_xfer && in_range;
  assign item.ch     = samples.channel;
  assign item.sample = samples.sample;

  // every in-flight sample holds a queue slot until it retires, so the queue never overflows
  assign pending_next = pending + PW'(item.v) - PW'(out_xfer) - PW'(blk_out.drop);

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending_next;
    end
  end

  assign samples.ready = pending < PW'(pkenv_pkg::OQ_DEPTH);

  // stage 1: envelope read-modify-write
  pkenv_env #(.MAX_CHANNELS(MAX_CHANNELS)) u_env (
    .clk           (clk),
    .rst           (rst),
    .item          (item),
    .alpha_attack  (alpha_attack),
    .alpha_release (alpha_release),
    .env_o         (env_item)
  );

  // stage 2: block maxima and count read-modify-write
  pkenv_blk #(.MAX_CHANNELS(MAX_CHANNELS), .MAX_BLOCK(MAX_BLOCK)) u_blk (
    .clk          (clk),
    .rst          (rst),
    .env_i        (env_item),
    .block_length (block_length),
    .blk_o        (blk_out)
  );

  // completed blocks wait here for the result transfer
  pkenv_oq u_oq (
    .clk       (clk),
    .rst       (rst),
    .push      (blk_out.push),
    .push_data (blk_out.res),
    .pop       (out_xfer),
    .valid     (oq_valid),
    .data      (oq_data)
  );

  assign peaks.valid       = oq_valid;
  assign peaks.out_channel = oq_data.ch;
  assign peaks.max_raw     = oq_data.max_raw;
  assign peaks.max_env     = oq_data.max_env;

endmodule

FILE: rtl/pkenv_chk.sv
// port-level checks for the peak envelope block, bound to the top level
module pkenv_chk (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_valid,
  input logic                          s_ready,
  input logic                          p_valid,
  input logic                          p_ready,
  input logic [pkenv_pkg::CH_W-1:0]    p_ch,
  input logic [pkenv_pkg::MAG_W-1:0]   p_raw,
  input logic [pkenv_pkg::MAG_W-1:0]   p_env
);

  // a result waiting for transfer keeps its payload
  a_hold: assert property (@(posedge clk) disable iff (rst)
    p_valid && !p_ready |=> p_valid && $stable(p_ch) && $stable(p_raw) && $stable(p_env))
    else $error("result changed while stalled");

  // a result appearing on an empty queue comes from an earlier sample transfer
  a_lat: assert property (@(posedge clk) disable iff (rst)
    $rose(p_valid) |-> $past(s_valid && s_ready, 4))
    else $error("result without matching sample transfer");

  // reset leaves no result pending and the sample side open
  a_rst: assert property (@(posedge clk)
    rst |=> !p_valid && s_ready)
    else $error("bad state after reset");

endmodule

bind peak_envelope_block_max_top pkenv_chk u_chk (
  .clk     (clk),
  .rst     (rst),
  .s_valid (samples.valid),
  .s_ready (samples.ready),
  .p_valid (peaks.valid),
  .p_ready (peaks.ready),
  .p_ch    (peaks.out_channel),
  .p_raw   (peaks.max_raw),
  .p_env   (peaks.max_env)
);
